// File: hdl/csg_pkg.sv
// Shared constants for the circle scanline span generator.
package csg_pkg;

    localparam int DEF_MAX_RADIUS = 32;
    localparam int DEF_COORD_BITS = 12;

    localparam int RADIUS_W = 6;
    localparam int SCREEN_ROWS_W = 12;
    localparam logic [SCREEN_ROWS_W-1:0] SCREEN_ROWS_RESET = 12'd1024;

endpackage

// File: hdl/csg_circle_if.sv
// Handshake channel that carries one circle request.
interface csg_circle_if #(
    parameter int COORD_BITS = csg_pkg::DEF_COORD_BITS
);
    logic                          valid;
    logic                          ready;
    logic [COORD_BITS-1:0]         center_x;
    logic [COORD_BITS-1:0]         center_y;
    logic [csg_pkg::RADIUS_W-1:0]  radius;

    modport source (output valid, output center_x, output center_y, output radius,
                    input ready);
    modport sink   (input valid, input center_x, input center_y, input radius,
                    output ready);
endinterface

// File: hdl/csg_span_if.sv
// Handshake channel that carries one span request.
interface csg_span_if #(
    parameter int COORD_BITS = csg_pkg::DEF_COORD_BITS
);
    logic                        valid;
    logic                        ready;
    logic [COORD_BITS-1:0]       row;
    logic signed [COORD_BITS:0]  span_start;
    logic [COORD_BITS:0]         span_end;
    logic                        last;

    modport source (output valid, output row, output span_start, output span_end,
                    output last, input ready);
    modport sink   (input valid, input row, input span_start, input span_end,
                    input last, output ready);
endinterface

// File: hdl/csg_row_seq.sv
// Row sequencer: checks a circle and walks its rows, one per advance.
module csg_row_seq #(
    parameter int MAX_RADIUS = csg_pkg::DEF_MAX_RADIUS,
    parameter int COORD_BITS = csg_pkg::DEF_COORD_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    csg_circle_if.sink                            circle,
    input  logic [csg_pkg::SCREEN_ROWS_W-1:0]     screen_rows,
    input  logic                                  advance,
    output logic                                  emit_valid,
    output logic [2*$clog2(MAX_RADIUS+1)-1:0]     emit_n,
    output logic [COORD_BITS-1:0]                 emit_row,
    output logic [COORD_BITS-1:0]                 emit_cx,
    output logic                                  emit_last
);
    import csg_pkg::*;

    localparam int ROOT_W = $clog2(MAX_RADIUS + 1);
    localparam int N_W    = 2 * ROOT_W;
    localparam int CNT_W  = ROOT_W + 1;
    localparam int CMP_W  = ((COORD_BITS > SCREEN_ROWS_W) ? COORD_BITS : SCREEN_ROWS_W) + 1;

    logic                  busy_reg,  busy_next;
    logic                  dec_reg,   dec_next;
    logic [CNT_W-1:0]      left_reg,  left_next;
    logic [ROOT_W-1:0]     dy_reg,    dy_next;
    logic [COORD_BITS-1:0] row_reg,   row_next;
    logic [COORD_BITS-1:0] cx_reg,    cx_next;
    logic [N_W-1:0]        n_reg,     n_next;

    logic [CMP_W-1:0]      cy_ext;
    logic [CMP_W-1:0]      r_ext;
    logic [ROOT_W-1:0]     r_trim;
    logic                  fits;
    logic                  start;
    logic                  emit;

    assign circle.ready = !busy_reg;

    assign cy_ext = CMP_W'(circle.center_y);
    assign r_ext  = CMP_W'(circle.radius);
    assign r_trim = circle.radius[ROOT_W-1:0];
    assign fits   = (circle.radius != '0)
                 && (circle.radius <= RADIUS_W'(MAX_RADIUS))
                 && (cy_ext > r_ext)
                 && ((cy_ext + r_ext) < CMP_W'(screen_rows));
    assign start  = circle.valid && circle.ready && fits;
    assign emit   = busy_reg && advance;

    assign emit_valid = emit;
    assign emit_n     = n_reg;
    assign emit_row   = row_reg;
    assign emit_cx    = cx_reg;
    assign emit_last  = (left_reg == CNT_W'(1));

    // n tracks radius^2 - dy^2 as dy steps by one
    always_comb
    begin
        busy_next = busy_reg;
        dec_next  = dec_reg;
        left_next = left_reg;
        dy_next   = dy_reg;
        row_next  = row_reg;
        cx_next   = cx_reg;
        n_next    = n_reg;
        if (start)
        begin
            busy_next = 1'b1;
            dec_next  = 1'b1;
            left_next = {r_trim, 1'b0};
            dy_next   = r_trim;
            row_next  = circle.center_y - COORD_BITS'(circle.radius);
            cx_next   = circle.center_x;
            n_next    = '0;
        end
        else if (emit)
        begin
            busy_next = (left_reg != CNT_W'(1));
            left_next = left_reg - CNT_W'(1);
            row_next  = row_reg + COORD_BITS'(1);
            if (dec_reg)
            begin
                dy_next  = dy_reg - ROOT_W'(1);
                dec_next = (dy_reg != ROOT_W'(1));
                n_next   = n_reg + N_W'({dy_reg, 1'b0}) - N_W'(1);
            end
            else
            begin
                dy_next = dy_reg + ROOT_W'(1);
                n_next  = n_reg - N_W'({dy_reg, 1'b1});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            dec_reg  <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            dec_reg  <= dec_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dy_reg  <= dy_next;
        row_reg <= row_next;
        cx_reg  <= cx_next;
        n_reg   <= n_next;
    end

endmodule

// File: hdl/csg_sqrt_pipe.sv
// Pipelined floor square root, one result bit per stage, with side payload.
module csg_sqrt_pipe #(
    parameter int ROOT_W = 6,
    parameter int PAY_W  = 25
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   in_n,
    input  logic [PAY_W-1:0]      in_pay,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output logic [PAY_W-1:0]      out_pay
);
    localparam int N_W = 2 * ROOT_W;
    localparam int T_W = N_W + 1;

    logic              valid_reg [ROOT_W];
    logic [N_W-1:0]    rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [PAY_W-1:0]  pay_reg   [ROOT_W];

    genvar i;
    for (i = 0; i < ROOT_W; i++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - i;

        logic              v_in;
        logic [N_W-1:0]    rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [PAY_W-1:0]  pay_in;
        logic [T_W-1:0]    trial;
        logic              fit;

        if (i == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_n;
            assign root_in = '0;
            assign pay_in  = in_pay;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign pay_in  = pay_reg[i-1];
        end

        // test (root + 2^B)^2 against n, kept as a remainder
        assign trial = (T_W'(root_in) << (B + 1)) + (T_W'(1) << (2 * B));
        assign fit   = ({1'b0, rem_in} >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                if (fit)
                begin
                    rem_reg[i]  <= rem_in - N_W'(trial);
                    root_reg[i] <= root_in | (ROOT_W'(1) << B);
                end
                else
                begin
                    rem_reg[i]  <= rem_in;
                    root_reg[i] <= root_in;
                end
                pay_reg[i] <= pay_in;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_pay   = pay_reg[ROOT_W-1];

endmodule

// File: hdl/circle_scanline_span_generator.sv
// Top level of the circle scanline span generator.
//
//  port     dir   kind        carries
//  circle   in    valid/ready center_x, center_y, radius
//  span     out   valid/ready row, span_start, span_end, last
//  cfg_*    in    write only  screen_rows (cfg_we, cfg_wdata)
//
// A circle yields 2*radius spans at one span per cycle when span is never stalled,
// after it is loaded; a rejected circle is taken and yields no spans. The span rate is set
// by the row sequencer; spans pass a ceil(log2(MAX_RADIUS+1))-stage root pipeline
// and an output register.
// Reset clears all valid bits and loads screen_rows with 1024.
// A stall on span freezes every stage together; circle is refused while rows remain.
module circle_scanline_span_generator #(
    parameter int MAX_RADIUS = csg_pkg::DEF_MAX_RADIUS,
    parameter int COORD_BITS = csg_pkg::DEF_COORD_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    csg_circle_if.sink                          circle,
    csg_span_if.source                          span,
    input  logic                                cfg_we,
    input  logic [csg_pkg::SCREEN_ROWS_W-1:0]   cfg_wdata
);
    import csg_pkg::*;

    localparam int ROOT_W = $clog2(MAX_RADIUS + 1);
    localparam int N_W    = 2 * ROOT_W;
    localparam int PAY_W  = 2 * COORD_BITS + 1;

    logic [SCREEN_ROWS_W-1:0]  screen_rows_reg;
    logic                      advance;

    logic                      emit_valid;
    logic [N_W-1:0]            emit_n;
    logic [COORD_BITS-1:0]     emit_row;
    logic [COORD_BITS-1:0]     emit_cx;
    logic                      emit_last;

    logic                      root_valid;
    logic [ROOT_W-1:0]         root;
    logic [PAY_W-1:0]          root_pay;
    logic [COORD_BITS-1:0]     pay_row;
    logic [COORD_BITS-1:0]     pay_cx;
    logic                      pay_last;
    logic [COORD_BITS:0]       d_ext;
    logic [COORD_BITS:0]       cx_ext;

    logic                      out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0]     out_row_reg;
    logic [COORD_BITS:0]       out_start_reg;
    logic [COORD_BITS:0]       out_end_reg;
    logic                      out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_rows_reg <= SCREEN_ROWS_RESET;
        end
        else if (cfg_we)
        begin
            screen_rows_reg <= cfg_wdata;
        end
    end

    assign advance = !out_valid_reg || span.ready;

    csg_row_seq #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_row_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .circle      (circle),
        .screen_rows (screen_rows_reg),
        .advance     (advance),
        .emit_valid  (emit_valid),
        .emit_n      (emit_n),
        .emit_row    (emit_row),
        .emit_cx     (emit_cx),
        .emit_last   (emit_last)
    );

    csg_sqrt_pipe #(
        .ROOT_W (ROOT_W),
        .PAY_W  (PAY_W)
    ) u_sqrt_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (emit_valid),
        .in_n      (emit_n),
        .in_pay    ({emit_row, emit_cx, emit_last}),
        .out_valid (root_valid),
        .out_root  (root),
        .out_pay   (root_pay)
    );

    assign {pay_row, pay_cx, pay_last} = root_pay;
    assign d_ext  = (COORD_BITS + 1)'(root);
    assign cx_ext = {1'b0, pay_cx};

    assign out_valid_next = advance ? root_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_row_reg   <= pay_row;
            out_start_reg <= cx_ext - d_ext;
            out_end_reg   <= cx_ext + d_ext;
            out_last_reg  <= pay_last;
        end
    end

    assign span.valid      = out_valid_reg;
    assign span.row        = out_row_reg;
    assign span.span_start = out_start_reg;
    assign span.span_end   = out_end_reg;
    assign span.last       = out_last_reg;

endmodule

// File: hdl/csg_checker.sv
// Port-level assertions for the circle scanline span generator, bound to the top.
module csg_checker #(
    parameter int COORD_BITS = csg_pkg::DEF_COORD_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [COORD_BITS-1:0]              in_center_y,
    input  logic [csg_pkg::RADIUS_W-1:0]       in_radius,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [COORD_BITS-1:0]              out_row,
    input  logic [COORD_BITS:0]                out_span_start,
    input  logic [COORD_BITS:0]                out_span_end,
    input  logic                               out_last
);
    import csg_pkg::*;

    a_span_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row)
            && $stable(out_span_start) && $stable(out_span_end) && $stable(out_last))
        else $error("span request changed while stalled");

    a_zero_radius_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_radius == '0) |=> in_ready)
        else $error("zero-radius circle blocked the input");

    a_top_edge_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_center_y <= COORD_BITS'(in_radius)) |=> in_ready)
        else $error("circle touching the top edge blocked the input");

    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last ##1 out_valid
            |-> out_row == $past(out_row) + COORD_BITS'(1))
        else $error("span rows of one circle not consecutive");

    a_span_parity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> out_span_end[0] == out_span_start[0])
        else $error("span not symmetric about its center");

endmodule

bind circle_scanline_span_generator csg_checker #(
    .COORD_BITS (COORD_BITS)
) u_csg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (circle.valid),
    .in_ready       (circle.ready),
    .in_center_y    (circle.center_y),
    .in_radius      (circle.radius),
    .out_valid      (span.valid),
    .out_ready      (span.ready),
    .out_row        (span.row),
    .out_span_start (span.span_start),
    .out_span_end   (span.span_end),
    .out_last       (span.last)
);

// File: tb/tb_circle_scanline_span_generator.sv
// Testbench for circle_scanline_span_generator: checks every span of each circle request.
module tb_circle_scanline_span_generator;

    timeunit 1ns;
    timeprecision 1ps;

    import csg_pkg::*;

    localparam int CB = DEF_COORD_BITS;
    localparam int MAX_R = DEF_MAX_RADIUS;
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        logic [CB-1:0]       cx;
        logic [CB-1:0]       cy;
        logic [RADIUS_W-1:0] r;
    } circle_t;

    typedef struct {
        logic [CB-1:0]        row;
        logic signed [CB:0]   span_start;
        logic [CB:0]          span_end;
        logic                 last;
    } span_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [SCREEN_ROWS_W-1:0] cfg_wdata;

    csg_circle_if #(.COORD_BITS(CB)) circle_ch ();
    csg_span_if   #(.COORD_BITS(CB)) span_ch ();

    circle_scanline_span_generator #(
        .MAX_RADIUS(MAX_R),
        .COORD_BITS(CB)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .circle    (circle_ch),
        .span      (span_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    circle_t     circles_pending[$];
    span_t       spans_due[$];
    int unsigned row_limit;
    int unsigned mismatches;
    bit          circle_taken;
    bit          quiet;
    bit          hold_go;
    bit          sink_hold;
    int unsigned src_gap;
    int unsigned snk_gap;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("** circle_scanline_span_generator: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void predict_spans(input circle_t c);
        int unsigned cx;
        int unsigned cy;
        int unsigned r;
        int unsigned row;
        int unsigned dy;
        int unsigned n;
        int unsigned d;
        int unsigned k;
        int          lo;
        int          hi;
        span_t       s;
        cx = c.cx;
        cy = c.cy;
        r  = c.r;
        if (r == 0 || r > MAX_R)
            return;
        if (!(cy > r && cy + r < row_limit))
            return;
        for (k = 0; k < 2 * r; k++)
        begin
            row = cy - r + k;
            dy  = (cy >= row) ? cy - row : row - cy;
            n   = r * r - dy * dy;
            d   = 0;
            while ((d + 1) * (d + 1) <= n)
                d++;
            lo = int'(cx) - int'(d);
            hi = int'(cx) + int'(d);
            s.row        = row[CB-1:0];
            s.span_start = lo[CB:0];
            s.span_end   = hi[CB:0];
            s.last       = (k + 1 == 2 * r);
            spans_due.push_back(s);
        end
    endfunction

    // Sample handshakes and configuration writes.
    always @(posedge clk)
    begin
        span_t got;
        span_t want;
        if (cfg_we)
            row_limit = cfg_wdata;
        if (rst_n && circle_ch.valid && circle_ch.ready)
        begin
            predict_spans(circles_pending[0]);
            circle_taken = 1'b1;
        end
        if (rst_n && span_ch.valid && span_ch.ready)
        begin
            got.row        = span_ch.row;
            got.span_start = span_ch.span_start;
            got.span_end   = span_ch.span_end;
            got.last       = span_ch.last;
            if (spans_due.size() == 0)
                report_mismatch($sformatf("unexpected span row %0d start %0d end %0d last %0b",
                    got.row, got.span_start, got.span_end, got.last));
            else
            begin
                want = spans_due.pop_front();
                if (got.row !== want.row)
                    report_mismatch($sformatf("row %0d, want %0d", got.row, want.row));
                if (got.span_start !== want.span_start)
                    report_mismatch($sformatf("row %0d span_start %0d, want %0d",
                        want.row, got.span_start, want.span_start));
                if (got.span_end !== want.span_end)
                    report_mismatch($sformatf("row %0d span_end %0d, want %0d",
                        want.row, got.span_end, want.span_end));
                if (got.last !== want.last)
                    report_mismatch($sformatf("row %0d last %0b, want %0b",
                        want.row, got.last, want.last));
            end
        end
    end

    // Drive circle requests from the pending queue.
    always @(negedge clk)
    begin
        logic offer;
        offer = circle_ch.valid;
        if (circle_taken)
        begin
            circles_pending.delete(0);
            circle_taken = 1'b0;
            offer = 1'b0;
        end
        if (!offer)
        begin
            if (src_gap > 0)
                src_gap--;
            else if (circles_pending.size() != 0)
            begin
                if (!quiet && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(0, 12);
                else
                begin
                    circle_ch.center_x <= circles_pending[0].cx;
                    circle_ch.center_y <= circles_pending[0].cy;
                    circle_ch.radius   <= circles_pending[0].r;
                    offer = 1'b1;
                end
            end
        end
        circle_ch.valid <= offer;
    end

    // Drive span ready with random stall bursts.
    always @(negedge clk)
    begin
        if (sink_hold)
            span_ch.ready <= 1'b0;
        else if (snk_gap > 0)
        begin
            snk_gap--;
            span_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            snk_gap = $urandom_range(0, 12);
            span_ch.ready <= 1'b0;
        end
        else
            span_ch.ready <= 1'b1;
    end

    // Hold off span acceptance so the block backs up onto its input.
    initial
    begin
        sink_hold = 1'b0;
        wait (hold_go);
        sink_hold = 1'b1;
        repeat (500) @(posedge clk);
        sink_hold = 1'b0;
    end

    task automatic add_circle(input int unsigned cx, input int unsigned cy,
                              input int unsigned r);
        circle_t c;
        c.cx = cx[CB-1:0];
        c.cy = cy[CB-1:0];
        c.r  = r[RADIUS_W-1:0];
        circles_pending.push_back(c);
    endtask

    task automatic add_random_circles(input int unsigned count);
        int unsigned made;
        int unsigned r;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 9) == 0)
                add_circle($urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 63));
            else
            begin
                r = $urandom_range(1, MAX_R);
                if (row_limit > 2 * r + 1)
                begin
                    add_circle($urandom_range(0, 4095),
                               $urandom_range(r + 1, row_limit - r - 1), r);
                    made++;
                end
                else
                    add_circle($urandom_range(0, 4095), $urandom_range(0, 4095), r);
            end
        end
    endtask

    task automatic wait_idle();
        while (circles_pending.size() != 0 || spans_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_screen_rows(input int unsigned rows);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= rows[SCREEN_ROWS_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int unsigned spin;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        circle_ch.valid = 1'b0;
        circle_ch.center_x = '0;
        circle_ch.center_y = '0;
        circle_ch.radius = '0;
        span_ch.ready = 1'b0;
        row_limit = SCREEN_ROWS_RESET;
        mismatches = 0;
        circle_taken = 1'b0;
        quiet = 1'b0;
        hold_go = 1'b0;
        src_gap = 0;
        snk_gap = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        add_circle(100, 100, 0);
        add_circle(100, 100, 33);
        add_circle(100, 100, 63);
        add_circle(100, 100, 1);
        add_circle(0, 32, 32);
        add_circle(0, 33, 32);
        add_circle(4095, 500, 32);
        add_circle(2048, 991, 32);
        add_circle(2048, 992, 32);
        add_circle(5, 1, 1);
        add_circle(5, 2, 1);
        add_circle(4095, 4095, 31);
        wait_idle();

        write_screen_rows(4095);
        add_circle(4095, 4062, 32);
        add_circle(4095, 4063, 32);
        add_circle(0, 4095, 1);
        add_circle(1, 2047, 17);
        add_random_circles(70);
        wait_idle();

        write_screen_rows(1);
        add_circle(10, 10, 1);
        add_circle(0, 0, 0);
        add_circle(4095, 4095, 32);
        add_random_circles(0);
        repeat (10)
            add_circle($urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 63));
        wait_idle();

        write_screen_rows(64);
        hold_go = 1'b1;
        add_random_circles(60);
        wait_idle();

        write_screen_rows(2000);
        add_random_circles(80);
        wait_idle();

        quiet = 1'b1;
        write_screen_rows(1024);
        add_random_circles(130);
        while (circles_pending.size() != 0)
            @(posedge clk);

        for (spin = 0; spin < 20000 && spans_due.size() != 0; spin++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (spans_due.size() != 0)
            report_mismatch($sformatf("%0d spans never arrived", spans_due.size()));

        if (mismatches == 0)
            $display("** circle_scanline_span_generator: PASSED **");
        else
            $display("** circle_scanline_span_generator: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
hdl/csg_pkg.sv
hdl/csg_circle_if.sv
hdl/csg_span_if.sv
hdl/csg_row_seq.sv
hdl/csg_sqrt_pipe.sv
hdl/circle_scanline_span_generator.sv
hdl/csg_checker.sv
tb/tb_circle_scanline_span_generator.sv
